/* rtl/rvid_pkg.sv */
package rvid_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_ALUIMM = 7'b0010011;
  localparam logic [6:0] OPC_ALUREG = 7'b0110011;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values, jump
  localparam logic [2:0] F3_JALR = 3'b000;

  // funct3 values, branches
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  // funct3 values, loads and stores
  localparam logic [2:0] F3_BYTE   = 3'b000;
  localparam logic [2:0] F3_HALF   = 3'b001;
  localparam logic [2:0] F3_WORD   = 3'b010;
  localparam logic [2:0] F3_BYTE_U = 3'b100;
  localparam logic [2:0] F3_HALF_U = 3'b101;

  // funct3 values, alu operations
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  // operation ids
  localparam logic [5:0] OP_LUI   = 6'd0;
  localparam logic [5:0] OP_AUIPC = 6'd1;
  localparam logic [5:0] OP_JAL   = 6'd2;
  localparam logic [5:0] OP_JALR  = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BLT   = 6'd6;
  localparam logic [5:0] OP_BGE   = 6'd7;
  localparam logic [5:0] OP_BLTU  = 6'd8;
  localparam logic [5:0] OP_BGEU  = 6'd9;
  localparam logic [5:0] OP_LB    = 6'd10;
  localparam logic [5:0] OP_LH    = 6'd11;
  localparam logic [5:0] OP_LW    = 6'd12;
  localparam logic [5:0] OP_LBU   = 6'd13;
  localparam logic [5:0] OP_LHU   = 6'd14;
  localparam logic [5:0] OP_SB    = 6'd15;
  localparam logic [5:0] OP_SH    = 6'd16;
  localparam logic [5:0] OP_SW    = 6'd17;
  localparam logic [5:0] OP_ADDI  = 6'd18;
  localparam logic [5:0] OP_SLTI  = 6'd19;
  localparam logic [5:0] OP_SLTIU = 6'd20;
  localparam logic [5:0] OP_XORI  = 6'd21;
  localparam logic [5:0] OP_ORI   = 6'd22;
  localparam logic [5:0] OP_ANDI  = 6'd23;
  localparam logic [5:0] OP_SLLI  = 6'd24;
  localparam logic [5:0] OP_SRLI  = 6'd25;
  localparam logic [5:0] OP_SRAI  = 6'd26;
  localparam logic [5:0] OP_ADD   = 6'd27;
  localparam logic [5:0] OP_SUB   = 6'd28;
  localparam logic [5:0] OP_SLL   = 6'd29;
  localparam logic [5:0] OP_SLT   = 6'd30;
  localparam logic [5:0] OP_SLTU  = 6'd31;
  localparam logic [5:0] OP_XOR   = 6'd32;
  localparam logic [5:0] OP_SRL   = 6'd33;
  localparam logic [5:0] OP_SRA   = 6'd34;
  localparam logic [5:0] OP_OR    = 6'd35;
  localparam logic [5:0] OP_AND   = 6'd36;

  // instruction formats
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_R    = 3'd1;
  localparam logic [2:0] FMT_I    = 3'd2;
  localparam logic [2:0] FMT_S    = 3'd3;
  localparam logic [2:0] FMT_B    = 3'd4;
  localparam logic [2:0] FMT_U    = 3'd5;
  localparam logic [2:0] FMT_J    = 3'd6;

  // one decoded instruction
  typedef struct packed {
    logic [5:0]  operation_id;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_one;
    logic [4:0]  src_reg_two;
    logic [4:0]  shift_amount;
    logic [31:0] immediate;
    logic        illegal;
  } dec_result_t;

endpackage

/* rtl/rv32i_instruction_decoder.sv */
// RV32I instruction decoder. One instruction word is accepted on every cycle
// that start is high (busy is tied low, so the decoder never refuses a beat).
// Each beat is registered, decoded by one level of combinational logic and
// registered again, so its result appears with done high from the edge after
// the accepting edge and stays for one cycle only. The receiver cannot
// stall: it must take the result in that cycle. Unrecognized encodings,
// including FENCE, ECALL, EBREAK and CSR instructions, give illegal = 1 with
// all other result fields zero.
module rv32i_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instruction_word,
  output logic               done,
  output logic [5:0]         operation_id,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_reg_one,
  output logic [4:0]         src_reg_two,
  output logic [4:0]         shift_amount,
  output logic signed [31:0] immediate,
  output logic               illegal
);

  logic                  in_valid;
  logic [31:0]           in_word;
  logic                  out_valid;
  rvid_pkg::dec_result_t dec;
  rvid_pkg::dec_result_t out_result;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_word <= instruction_word;
    end
  end

  rvid_decode u_decode (
    .instruction_word (in_word),
    .result           (dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    if (in_valid) begin
      out_result <= dec;
    end
  end

  assign done         = out_valid;
  assign operation_id = out_result.operation_id;
  assign dest_reg     = out_result.dest_reg;
  assign src_reg_one  = out_result.src_reg_one;
  assign src_reg_two  = out_result.src_reg_two;
  assign shift_amount = out_result.shift_amount;
  assign immediate    = out_result.immediate;
  assign illegal      = out_result.illegal;

endmodule

/* rtl/rvid_decode.sv */
module rvid_decode (
  input  logic [31:0]         instruction_word,
  output rvid_pkg::dec_result_t result
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] op;
  logic       legal;
  logic [2:0] fmt;
  logic       shift;

  assign opc = instruction_word[6:0];
  assign f3  = instruction_word[14:12];
  assign f7  = instruction_word[31:25];

  // operation, format and legality from opcode and funct fields
  always_comb begin
    op    = rvid_pkg::OP_LUI;
    legal = 1'b0;
    fmt   = rvid_pkg::FMT_NONE;
    shift = 1'b0;
    case (opc)
      rvid_pkg::OPC_LUI: begin
        op = rvid_pkg::OP_LUI; fmt = rvid_pkg::FMT_U; legal = 1'b1;
      end
      rvid_pkg::OPC_AUIPC: begin
        op = rvid_pkg::OP_AUIPC; fmt = rvid_pkg::FMT_U; legal = 1'b1;
      end
      rvid_pkg::OPC_JAL: begin
        op = rvid_pkg::OP_JAL; fmt = rvid_pkg::FMT_J; legal = 1'b1;
      end
      rvid_pkg::OPC_JALR: begin
        op = rvid_pkg::OP_JALR; fmt = rvid_pkg::FMT_I;
        legal = (f3 == rvid_pkg::F3_JALR);
      end
      rvid_pkg::OPC_BRANCH: begin
        fmt = rvid_pkg::FMT_B;
        legal = 1'b1;
        case (f3)
          rvid_pkg::F3_BEQ:  op = rvid_pkg::OP_BEQ;
          rvid_pkg::F3_BNE:  op = rvid_pkg::OP_BNE;
          rvid_pkg::F3_BLT:  op = rvid_pkg::OP_BLT;
          rvid_pkg::F3_BGE:  op = rvid_pkg::OP_BGE;
          rvid_pkg::F3_BLTU: op = rvid_pkg::OP_BLTU;
          rvid_pkg::F3_BGEU: op = rvid_pkg::OP_BGEU;
          default:           legal = 1'b0;
        endcase
      end
      rvid_pkg::OPC_LOAD: begin
        fmt = rvid_pkg::FMT_I;
        legal = 1'b1;
        case (f3)
          rvid_pkg::F3_BYTE:   op = rvid_pkg::OP_LB;
          rvid_pkg::F3_HALF:   op = rvid_pkg::OP_LH;
          rvid_pkg::F3_WORD:   op = rvid_pkg::OP_LW;
          rvid_pkg::F3_BYTE_U: op = rvid_pkg::OP_LBU;
          rvid_pkg::F3_HALF_U: op = rvid_pkg::OP_LHU;
          default:             legal = 1'b0;
        endcase
      end
      rvid_pkg::OPC_STORE: begin
        fmt = rvid_pkg::FMT_S;
        legal = 1'b1;
        case (f3)
          rvid_pkg::F3_BYTE: op = rvid_pkg::OP_SB;
          rvid_pkg::F3_HALF: op = rvid_pkg::OP_SH;
          rvid_pkg::F3_WORD: op = rvid_pkg::OP_SW;
          default:           legal = 1'b0;
        endcase
      end
      rvid_pkg::OPC_ALUIMM: begin
        fmt = rvid_pkg::FMT_I;
        legal = 1'b1;
        case (f3)
          rvid_pkg::F3_ADD:  op = rvid_pkg::OP_ADDI;
          rvid_pkg::F3_SLT:  op = rvid_pkg::OP_SLTI;
          rvid_pkg::F3_SLTU: op = rvid_pkg::OP_SLTIU;
          rvid_pkg::F3_XOR:  op = rvid_pkg::OP_XORI;
          rvid_pkg::F3_OR:   op = rvid_pkg::OP_ORI;
          rvid_pkg::F3_AND:  op = rvid_pkg::OP_ANDI;
          rvid_pkg::F3_SLL: begin
            op = rvid_pkg::OP_SLLI;
            shift = 1'b1;
            legal = (f7 == rvid_pkg::F7_BASE);
          end
          rvid_pkg::F3_SR: begin
            shift = 1'b1;
            if (f7 == rvid_pkg::F7_ALT) begin
              op = rvid_pkg::OP_SRAI;
            end else begin
              op = rvid_pkg::OP_SRLI;
              legal = (f7 == rvid_pkg::F7_BASE);
            end
          end
          default: legal = 1'b0;
        endcase
      end
      rvid_pkg::OPC_ALUREG: begin
        fmt = rvid_pkg::FMT_R;
        legal = 1'b1;
        if (f7 == rvid_pkg::F7_BASE) begin
          case (f3)
            rvid_pkg::F3_ADD:  op = rvid_pkg::OP_ADD;
            rvid_pkg::F3_SLL:  op = rvid_pkg::OP_SLL;
            rvid_pkg::F3_SLT:  op = rvid_pkg::OP_SLT;
            rvid_pkg::F3_SLTU: op = rvid_pkg::OP_SLTU;
            rvid_pkg::F3_XOR:  op = rvid_pkg::OP_XOR;
            rvid_pkg::F3_SR:   op = rvid_pkg::OP_SRL;
            rvid_pkg::F3_OR:   op = rvid_pkg::OP_OR;
            rvid_pkg::F3_AND:  op = rvid_pkg::OP_AND;
            default:           legal = 1'b0;
          endcase
        end else if (f7 == rvid_pkg::F7_ALT) begin
          case (f3)
            rvid_pkg::F3_ADD: op = rvid_pkg::OP_SUB;
            rvid_pkg::F3_SR:  op = rvid_pkg::OP_SRA;
            default:          legal = 1'b0;
          endcase
        end else begin
          legal = 1'b0;
        end
      end
      default: legal = 1'b0;
    endcase
  end

  // field extraction; everything but illegal is zero for an unknown encoding
  always_comb begin
    result = '0;
    if (!legal) begin
      result.illegal = 1'b1;
    end else begin
      result.operation_id = op;
      if (fmt == rvid_pkg::FMT_R || fmt == rvid_pkg::FMT_I ||
          fmt == rvid_pkg::FMT_U || fmt == rvid_pkg::FMT_J) begin
        result.dest_reg = instruction_word[11:7];
      end
      if (fmt == rvid_pkg::FMT_R || fmt == rvid_pkg::FMT_I ||
          fmt == rvid_pkg::FMT_S || fmt == rvid_pkg::FMT_B) begin
        result.src_reg_one = instruction_word[19:15];
      end
      if (fmt == rvid_pkg::FMT_R || fmt == rvid_pkg::FMT_S ||
          fmt == rvid_pkg::FMT_B) begin
        result.src_reg_two = instruction_word[24:20];
      end
      if (shift) begin
        result.shift_amount = instruction_word[24:20];
      end
      case (fmt)
        rvid_pkg::FMT_I: result.immediate =
          {{20{instruction_word[31]}}, instruction_word[31:20]};
        rvid_pkg::FMT_S: result.immediate =
          {{20{instruction_word[31]}}, instruction_word[31:25], instruction_word[11:7]};
        rvid_pkg::FMT_B: result.immediate =
          {{19{instruction_word[31]}}, instruction_word[31], instruction_word[7],
           instruction_word[30:25], instruction_word[11:8], 1'b0};
        rvid_pkg::FMT_U: result.immediate = {instruction_word[31:12], 12'b0};
        rvid_pkg::FMT_J: result.immediate =
          {{11{instruction_word[31]}}, instruction_word[31], instruction_word[19:12],
           instruction_word[20], instruction_word[30:21], 1'b0};
        default: result.immediate = '0;
      endcase
    end
  end

endmodule
